/* hw/rtl/sgns_pkg.sv */
// Package with the shared constants and types of the SOM grid neighborhood search.
package sgns_pkg;

    localparam int MAX_WIDTH  = 8;
    localparam int MAX_HEIGHT = 8;

    localparam int COORD_W = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
    localparam int SIZE_W  = 4;
    localparam int INDEX_W = 6;
    localparam int RADIUS_W = 10;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_LAYOUT_HEXA = 2'd0;
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH
    } sgns_state_t;

endpackage

/* hw/rtl/sgns_if.sv */
// Handshake interfaces for the request and result channels.
interface sgns_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] center_x;
    logic [2:0] center_y;
    logic [9:0] radius_sq_x4;

    modport source (output valid, output center_x, output center_y, output radius_sq_x4,
                    input ready);
    modport sink (input valid, input center_x, input center_y, input radius_sq_x4,
                  output ready);
endinterface

interface sgns_rsp_if;
    logic       valid;
    logic       ready;
    logic [5:0] cell_index;
    logic       empty_res;
    logic       last;

    modport source (output valid, output cell_index, output empty_res, output last,
                    input ready);
    modport sink (input valid, input cell_index, input empty_res, input last,
                  output ready);
endinterface

/* hw/rtl/sgns_dist.sv */
// Distance test unit that checks one grid cell against the center and radius.
module sgns_dist
    import sgns_pkg::*;
(
    input  logic                 hexa,
    input  logic [COORD_W-1:0]   center_x,
    input  logic [COORD_W-1:0]   center_y,
    input  logic [COORD_W-1:0]   col,
    input  logic [COORD_W-1:0]   row,
    input  logic [RADIUS_W-1:0]  radius,
    output logic                 hit
);

    logic signed [COORD_W+1:0] dx;
    logic signed [COORD_W+1:0] dy;
    logic signed [COORD_W+2:0] h;
    logic        [COORD_W:0]   abs_h;
    logic        [COORD_W-1:0] abs_dx;
    logic        [COORD_W-1:0] abs_dy;
    logic        [9:0]         sq_h;
    logic        [9:0]         sq_dx;
    logic        [9:0]         sq_dy;
    logic        [9:0]         dist_sq;

    always_comb
    begin
        dx = $signed({2'b00, center_x}) - $signed({2'b00, col});
        dy = $signed({2'b00, center_y}) - $signed({2'b00, row});
        h  = {dx, 1'b0};
        if (dy[0])
        begin
            if (center_y[0])
            begin
                h = h + (COORD_W+3)'(1);
            end
            else
            begin
                h = h - (COORD_W+3)'(1);
            end
        end
        abs_h  = h[COORD_W+2] ? (COORD_W+1)'(-h) : h[COORD_W:0];
        abs_dx = dx[COORD_W+1] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        abs_dy = dy[COORD_W+1] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        sq_h   = 10'(abs_h) * 10'(abs_h);
        sq_dx  = 10'(abs_dx) * 10'(abs_dx);
        sq_dy  = 10'(abs_dy) * 10'(abs_dy);
        if (hexa)
        begin
            dist_sq = sq_h + 10'(sq_dy * 10'd3);
        end
        else
        begin
            dist_sq = 10'((sq_dx + sq_dy) << 2);
        end
        hit = (dist_sq <= radius);
    end

endmodule

/* hw/rtl/som_grid_neighborhood_search.sv */
// Top level of the SOM grid neighborhood search with its register port and sweep sequencer.
// A request is taken only while the block is idle; it then tests one grid cell per
// cycle in index order with a single distance unit, while no hit waits on a stalled
// result channel, over the grid size in use after saturation (accept, sweep, final
// flush). A zero-sized grid goes from the accept straight to the flush state, which
// registers its empty result once the output register is free.
// Each hit waits in a pending register until the next hit so that the final result can
// carry last; an output register lets the next request in while the final result waits.
module som_grid_neighborhood_search
    import sgns_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    sgns_req_if.sink           req,
    sgns_rsp_if.source         rsp
);

    sgns_state_t state_reg, state_next;

    logic                layout_hexa_reg;
    logic [SIZE_W-1:0]   grid_width_reg;
    logic [SIZE_W-1:0]   grid_height_reg;

    logic [COORD_W-1:0]  cx_reg, cx_next;
    logic [COORD_W-1:0]  cy_reg, cy_next;
    logic [RADIUS_W-1:0] rad_reg, rad_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic [INDEX_W-1:0]  idx_reg, idx_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [INDEX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_idx_reg, out_idx_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_last_reg, out_last_next;

    logic [SIZE_W-1:0]   w_eff;
    logic [SIZE_W-1:0]   h_eff;
    logic                size_zero;
    logic                col_last;
    logic                cell_last;
    logic                hit;
    logic                out_free;
    logic                step;
    logic                cfg_write;

    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_hexa_reg <= 1'b0;
            grid_width_reg  <= SIZE_W'(MAX_WIDTH);
            grid_height_reg <= SIZE_W'(MAX_HEIGHT);
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_LAYOUT_HEXA: layout_hexa_reg <= pwdata[0];
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[SIZE_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[SIZE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LAYOUT_HEXA: prdata = PDATA_W'(layout_hexa_reg);
            REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

    assign w_eff     = (grid_width_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH)
                                                              : grid_width_reg;
    assign h_eff     = (grid_height_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT)
                                                                : grid_height_reg;
    assign size_zero = (w_eff == '0) || (h_eff == '0);
    assign col_last  = ({1'b0, col_reg} == w_eff - SIZE_W'(1));
    assign cell_last = col_last && ({1'b0, row_reg} == h_eff - SIZE_W'(1));
    assign out_free  = !out_valid_reg || rsp.ready;
    assign step      = !(hit && pend_valid_reg) || out_free;

    sgns_dist u_dist (
        .hexa     (layout_hexa_reg),
        .center_x (cx_reg),
        .center_y (cy_reg),
        .col      (col_reg),
        .row      (row_reg),
        .radius   (rad_reg),
        .hit      (hit)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = size_zero ? ST_FLUSH : ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (step && cell_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready      = (state_reg == ST_IDLE);
        rsp.valid      = out_valid_reg;
        rsp.cell_index = out_idx_reg;
        rsp.empty_res  = out_empty_reg;
        rsp.last       = out_last_reg;
    end

    always_comb
    begin
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        rad_next        = rad_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_idx_next    = out_idx_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cx_next         = req.center_x;
                    cy_next         = req.center_y;
                    rad_next        = req.radius_sq_x4;
                    col_next        = '0;
                    row_next        = '0;
                    idx_next        = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_SWEEP:
            begin
                if (step)
                begin
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_idx_next   = pend_idx_reg;
                            out_empty_next = 1'b0;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = idx_reg;
                    end
                    if (col_last)
                    begin
                        col_next = '0;
                        row_next = row_reg + COORD_W'(1);
                    end
                    else
                    begin
                        col_next = col_reg + COORD_W'(1);
                    end
                    idx_next = idx_reg + INDEX_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_idx_next   = pend_idx_reg;
                        out_empty_next = 1'b0;
                    end
                    else
                    begin
                        out_idx_next   = '0;
                        out_empty_next = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        rad_reg       <= rad_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        idx_reg       <= idx_next;
        pend_idx_reg  <= pend_idx_next;
        out_idx_reg   <= out_idx_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

endmodule

/* tb/sv/sgns_nbr_checker.sv */
// Checker that predicts the neighbor cells of each request and compares every result item.
`timescale 1ns / 100ps

module sgns_nbr_checker
    import sgns_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    sgns_req_if                req,
    sgns_rsp_if                rsp,
    output int                 fail_cnt,
    output int                 pending_cnt
);

    typedef struct packed {
        logic [INDEX_W-1:0] cell_index;
        logic               empty_res;
        logic               last;
    } neighbor_t;

    neighbor_t         neighbor_q[$];
    logic              cfg_hexa;
    logic [SIZE_W-1:0] cfg_width;
    logic [SIZE_W-1:0] cfg_height;

    task automatic predict_neighbors(input logic [2:0] cx, input logic [2:0] cy,
                                     input logic [RADIUS_W-1:0] rad);
        int        w;
        int        h;
        int        dx;
        int        dy;
        int        hd;
        int        dist_sq;
        bit        have_hit;
        neighbor_t hit;
        w = (int'(cfg_width) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
        h = (int'(cfg_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height);
        have_hit = 1'b0;
        hit = '0;
        for (int i = 0; i < w * h; i++)
        begin
            dx = int'(cx) - (i % w);
            dy = int'(cy) - (i / w);
            if (!cfg_hexa)
            begin
                dist_sq = 4 * dx * dx + 4 * dy * dy;
            end
            else
            begin
                hd = 2 * dx;
                if ((dy & 1) != 0)
                begin
                    hd = cy[0] ? hd + 1 : hd - 1;
                end
                dist_sq = hd * hd + 3 * dy * dy;
            end
            if (dist_sq <= int'(rad))
            begin
                if (have_hit)
                begin
                    neighbor_q.insert(neighbor_q.size(), hit);
                end
                hit.cell_index = i[INDEX_W-1:0];
                hit.empty_res = 1'b0;
                hit.last = 1'b0;
                have_hit = 1'b1;
            end
        end
        if (have_hit)
        begin
            hit.last = 1'b1;
            neighbor_q.insert(neighbor_q.size(), hit);
        end
        else
        begin
            hit.cell_index = '0;
            hit.empty_res = 1'b1;
            hit.last = 1'b1;
            neighbor_q.insert(neighbor_q.size(), hit);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        neighbor_t exp_item;
        if (!rst_n)
        begin
            cfg_hexa = 1'b0;
            cfg_width = SIZE_W'(MAX_WIDTH);
            cfg_height = SIZE_W'(MAX_HEIGHT);
            neighbor_q.delete();
            fail_cnt = 0;
            pending_cnt = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[PADDR_W-1:2])
                    REG_LAYOUT_HEXA: cfg_hexa = pwdata[0];
                    REG_GRID_WIDTH:  cfg_width = pwdata[SIZE_W-1:0];
                    REG_GRID_HEIGHT: cfg_height = pwdata[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (neighbor_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got cell_index=%0d empty_res=%0d last=%0d",
                             $time, rsp.cell_index, rsp.empty_res, rsp.last);
                    fail_cnt++;
                end
                else
                begin
                    exp_item = neighbor_q.pop_front();
                    if (rsp.cell_index !== exp_item.cell_index)
                    begin
                        $display("%0t: cell_index mismatch, expected %0d, got %0d",
                                 $time, exp_item.cell_index, rsp.cell_index);
                        fail_cnt++;
                    end
                    if (rsp.empty_res !== exp_item.empty_res)
                    begin
                        $display("%0t: empty_res mismatch, expected %0d, got %0d",
                                 $time, exp_item.empty_res, rsp.empty_res);
                        fail_cnt++;
                    end
                    if (rsp.last !== exp_item.last)
                    begin
                        $display("%0t: last mismatch, expected %0d, got %0d",
                                 $time, exp_item.last, rsp.last);
                        fail_cnt++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                predict_neighbors(req.center_x, req.center_y, req.radius_sq_x4);
            end
            pending_cnt = neighbor_q.size();
        end
    end

endmodule

/* tb/sv/tb_som_grid_neighborhood_search.sv */
// Testbench top that drives requests and register writes and reports the verdict.
`timescale 1ns / 100ps

module tb_som_grid_neighborhood_search;
    import sgns_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_cnt;
    int                 pending_cnt;
    int                 src_idle_pct;
    int                 snk_stall_pct;
    int                 cycle_cnt;
    logic               holding;
    event               hold_ev;

    sgns_req_if req_ch ();
    sgns_rsp_if rsp_ch ();

    som_grid_neighborhood_search i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch.sink),
        .rsp     (rsp_ch.source)
    );

    sgns_nbr_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= !holding && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_ev);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        logic [PDATA_W-1:0] data;
        data = $urandom();
        data[3:0] = val;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_cnt != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_grid(input logic hexa, input logic [3:0] w, input logic [3:0] h);
        wait_drain();
        write_reg(REG_LAYOUT_HEXA, {3'b000, hexa});
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
    endtask

    task automatic send_req(input logic [2:0] cx, input logic [2:0] cy, input logic [9:0] rad);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.center_x <= cx;
        req_ch.center_y <= cy;
        req_ch.radius_sq_x4 <= rad;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    function automatic logic [3:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 6)
        begin
            return 4'd0;
        end
        if (r < 16)
        begin
            return 4'($urandom_range(15, 9));
        end
        return 4'($urandom_range(8, 1));
    endfunction

    function automatic logic [9:0] pick_radius();
        int r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return 10'($urandom_range(1023));
        end
        return 10'($urandom_range(64));
    endfunction

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.center_x = '0;
        req_ch.center_y = '0;
        req_ch.radius_sq_x4 = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_req(3'd0, 3'd0, 10'd0);
        send_req(3'd7, 3'd7, 10'd1023);
        send_req(3'd7, 3'd0, 10'd4);
        send_req(3'd3, 3'd5, 10'd3);
        send_req(3'd2, 3'd6, 10'd8);
        send_req(3'd5, 3'd2, 10'd1000);

        set_grid(1'b1, 4'd8, 4'd8);
        send_req(3'd3, 3'd2, 10'd3);
        send_req(3'd3, 3'd2, 10'd4);
        send_req(3'd4, 3'd5, 10'd4);
        send_req(3'd0, 3'd7, 10'd12);
        send_req(3'd7, 3'd0, 10'd1023);
        send_req(3'd6, 3'd3, 10'd0);

        // A grid with no columns or no rows gives only the empty result.
        set_grid(1'b0, 4'd0, 4'd8);
        send_req(3'd1, 3'd1, 10'd1023);
        set_grid(1'b1, 4'd5, 4'd0);
        send_req(3'd2, 3'd3, 10'd1023);

        // Sizes beyond the maximum saturate.
        set_grid(1'b0, 4'd15, 4'd9);
        send_req(3'd7, 3'd7, 10'd1023);
        send_req(3'd0, 3'd0, 10'd20);
        set_grid(1'b1, 4'd12, 4'd15);
        send_req(3'd3, 3'd3, 10'd50);

        set_grid(1'b1, 4'd1, 4'd1);
        send_req(3'd0, 3'd0, 10'd0);
        send_req(3'd7, 3'd7, 10'd100);

        // The center may lie outside the grid in use.
        set_grid(1'b0, 4'd3, 4'd2);
        send_req(3'd7, 3'd7, 10'd100);
        send_req(3'd6, 3'd5, 10'd1023);
        set_grid(1'b1, 4'd3, 4'd2);
        send_req(3'd5, 3'd5, 10'd200);

        // A write to an unmapped register must leave the settings alone.
        wait_drain();
        write_reg(REG_UNUSED, 4'd1);
        send_req(3'd1, 3'd0, 10'd16);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 56; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 56; end
                default: begin src_idle_pct = 25; snk_stall_pct = 25; end
            endcase
            for (int blk = 0; blk < 4; blk++)
            begin
                set_grid(1'($urandom_range(1)), pick_size(), pick_size());
                if ($urandom_range(3) == 0)
                begin
                    write_reg(REG_UNUSED, 4'($urandom_range(15)));
                end
                for (int n = 0; n < 18; n++)
                begin
                    if (phase == 0 && blk == 1 && n == 1)
                    begin
                        -> hold_ev;
                    end
                    send_req(3'($urandom_range(7)), 3'($urandom_range(7)), pick_radius());
                end
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
